// ===== hw/rtl/sqi_pkg.sv =====
`default_nettype none
package sqi_pkg;

    localparam int WORD_W    = 32;
    localparam int EPS_W     = 16;
    localparam int IN_W      = 9 * WORD_W;
    localparam int OUT_W     = 6 * WORD_W;
    localparam int USER_W    = 3;

    localparam int SQ_IN_W   = 64;
    localparam int SQ_ROOT_W = 32;
    localparam int SQ_REM_W  = 34;
    localparam int DV_W      = 32;
    localparam int NMAG_W    = 34;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_TWO  = 2'd2;
    localparam logic [1:0] KIND_INF  = 2'd3;

    localparam logic [1:0] CLS_ZERO  = 2'd0;
    localparam logic [1:0] CLS_INF   = 2'd1;
    localparam logic [1:0] CLS_ONE   = 2'd2;
    localparam logic [1:0] CLS_TWO   = 2'd3;

    typedef struct packed {
        logic [1:0]              cls;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic [2:0][WORD_W-1:0]  p1;
        logic [2:0][WORD_W-1:0]  p2;
        logic                    neg1;
        logic                    neg2;
    } t_side;

endpackage
`default_nettype wire

// ===== hw/rtl/sqi_sqrt_cell.sv =====
`default_nettype none
module sqi_sqrt_cell (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [sqi_pkg::SQ_IN_W-1:0]     i_v,
    input  logic [sqi_pkg::SQ_REM_W-1:0]    i_rem,
    input  logic [sqi_pkg::SQ_ROOT_W-1:0]   i_root,
    output logic [sqi_pkg::SQ_IN_W-1:0]     o_v,
    output logic [sqi_pkg::SQ_REM_W-1:0]    o_rem,
    output logic [sqi_pkg::SQ_ROOT_W-1:0]   o_root
);
    import sqi_pkg::*;

    logic [SQ_IN_W-1:0]   r_v;
    logic [SQ_REM_W-1:0]  r_rem;
    logic [SQ_ROOT_W-1:0] r_root;
    logic [SQ_REM_W:0]    rem_t;
    logic [SQ_REM_W:0]    trial;
    logic                 ge;
    logic [SQ_IN_W-1:0]   n_v;
    logic [SQ_REM_W-1:0]  n_rem;
    logic [SQ_ROOT_W-1:0] n_root;

    // one root bit per cell
    always_comb begin
        rem_t  = {i_rem[SQ_REM_W-2:0], i_v[SQ_IN_W-1:SQ_IN_W-2]};
        trial  = {1'b0, i_root, 2'b01};
        ge     = (rem_t >= trial);
        n_rem  = ge ? SQ_REM_W'(rem_t - trial) : SQ_REM_W'(rem_t);
        n_root = {i_root[SQ_ROOT_W-2:0], ge};
        n_v    = {i_v[SQ_IN_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_v;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_v    = r_v;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ===== hw/rtl/sqi_div_cell.sv =====
`default_nettype none
module sqi_div_cell #(
    parameter int DW = 50
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [DW-1:0]              i_dq,
    input  logic [sqi_pkg::DV_W-1:0]   i_rem,
    input  logic [sqi_pkg::DV_W-1:0]   i_dvs,
    output logic [DW-1:0]              o_dq,
    output logic [sqi_pkg::DV_W-1:0]   o_rem,
    output logic [sqi_pkg::DV_W-1:0]   o_dvs
);
    import sqi_pkg::*;

    logic [DW-1:0]   r_dq;
    logic [DV_W-1:0] r_rem;
    logic [DV_W-1:0] r_dvs;
    logic [DV_W:0]   rem_t;
    logic            ge;
    logic [DW-1:0]   n_dq;
    logic [DV_W-1:0] n_rem;

    // one quotient bit per cell, quotient shifts in behind the dividend
    always_comb begin
        rem_t = {i_rem, i_dq[DW-1]};
        ge    = (rem_t >= {1'b0, i_dvs});
        n_rem = ge ? DV_W'(rem_t - {1'b0, i_dvs}) : DV_W'(rem_t);
        n_dq  = {i_dq[DW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dq  <= n_dq;
            r_rem <= n_rem;
            r_dvs <= i_dvs;
        end
    end

    assign o_dq  = r_dq;
    assign o_rem = r_rem;
    assign o_dvs = r_dvs;

endmodule
`default_nettype wire

// ===== hw/rtl/segment_quadratic_intersection_top.sv =====
// throughput: one request per cycle while the skid buffer is empty, set by
// the row of 32 square root cells and two rows of 34 + FRAC_BITS divider
// cells, each one stage deep
// reset: synchronous active low, clears valid state, skid and near_zero
`default_nettype none
module segment_quadratic_intersection_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sqi_pkg::EPS_W-1:0]   i_cfg_wdata,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // coef_a, coef_b, coef_c, start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [sqi_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    output logic [sqi_pkg::OUT_W-1:0]   o_m_axis_tdata,
    // hit_kind, hit
    output logic [sqi_pkg::USER_W-1:0]  o_m_axis_tuser
);
    import sqi_pkg::*;

    localparam int DW  = NMAG_W + FRAC_BITS;
    localparam int NST = 39 + DW;
    localparam int PW  = FRAC_BITS + 35;
    localparam int TW  = FRAC_BITS + 1;
    localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

    function automatic logic [WORD_W-1:0] sat36(input logic signed [35:0] v);
        logic [WORD_W-1:0] res;
        if (v > 36'sd2147483647) begin
            res = 32'h7fff_ffff;
        end else if (v < -36'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[WORD_W-1:0];
        end
        return res;
    endfunction

    logic                 en;
    logic                 accept;
    logic [EPS_W-1:0]     r_near_zero;
    logic [NST-1:0]       r_vld;

    // stage 0
    logic signed [WORD_W-1:0] r0_a, r0_b, r0_c;
    logic [2:0][WORD_W-1:0]   r0_p1, r0_p2;
    // stage 1
    logic signed [63:0]       r1_bb, r1_ac;
    logic                     r1_a_small, r1_c_big;
    logic signed [WORD_W-1:0] r1_a, r1_b;
    logic [2:0][WORD_W-1:0]   r1_p1, r1_p2;
    // stage 2
    logic signed [63:0]       q;
    logic signed [63:0]       big_e;
    logic [1:0]               n_cls;
    logic [SQ_IN_W-1:0]       r2_q;
    t_side                    r2_sd;

    // square root row
    logic [SQ_ROOT_W:0][SQ_IN_W-1:0]   sq_v;
    logic [SQ_ROOT_W:0][SQ_REM_W-1:0]  sq_rem;
    logic [SQ_ROOT_W:0][SQ_ROOT_W-1:0] sq_root;
    t_side                             r_sq_sd [SQ_ROOT_W];

    // numerator stage
    t_side                    sq_out;
    t_side                    n3_sd;
    logic signed [35:0]       mb, s2, n1, n2, m1, m2;
    logic [DW-1:0]            r3_dq1, r3_dq2;
    logic [DV_W-1:0]          r3_dvs;
    t_side                    r3_sd;

    // divider rows
    logic [DW:0][DW-1:0]      dv_dq1, dv_dq2;
    logic [DW:0][DV_W-1:0]    dv_rem1, dv_rem2, dv_dvs1, dv_dvs2;
    t_side                    r_dv_sd [DW];

    // root check stage
    t_side                    dv_out;
    logic [DW-1:0]            qt1, qt2, eps_q;
    logic                     ok1, ok2, gt1, gt2, lt1, lt2;
    logic [1:0]               n_kind;
    logic [1:0]               r5_kind;
    logic                     r5_uf, r5_us;
    logic [TW-1:0]            r5_tf, r5_ts;
    logic signed [32:0]       r5_d [3];
    logic [2:0][WORD_W-1:0]   r5_p1;

    // product stage
    logic signed [PW-1:0]     r6_pf [3];
    logic signed [PW-1:0]     r6_ps [3];
    logic [1:0]               r6_kind;
    logic                     r6_uf, r6_us;
    logic [2:0][WORD_W-1:0]   r6_p1;

    // point stage
    logic [5:0][WORD_W-1:0]   n_pts;
    logic [OUT_W-1:0]         r7_data;
    logic [USER_W-1:0]        r7_user;

    // output and skid
    logic                     r_out_v, r_skid_v;
    logic [OUT_W-1:0]         r_out_d, r_skid_d;
    logic [USER_W-1:0]        r_out_u, r_skid_u;

    assign en              = !r_skid_v;
    assign accept          = i_s_axis_tvalid && en;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_zero <= '0;
        end else if (i_cfg_we) begin
            r_near_zero <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_a  <= $signed(i_s_axis_tdata[31:0]);
            r0_b  <= $signed(i_s_axis_tdata[63:32]);
            r0_c  <= $signed(i_s_axis_tdata[95:64]);
            r0_p1 <= i_s_axis_tdata[191:96];
            r0_p2 <= i_s_axis_tdata[287:192];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_bb      <= r0_b * r0_b;
            r1_ac      <= r0_a * r0_c;
            r1_a_small <= (r0_a <= $signed({1'b0, r_near_zero}));
            r1_c_big   <= (r0_c > $signed({1'b0, r_near_zero}));
            r1_a       <= r0_a;
            r1_b       <= r0_b;
            r1_p1      <= r0_p1;
            r1_p2      <= r0_p2;
        end
    end

    always_comb begin
        big_e = $signed(64'(r_near_zero) << FRAC_BITS);
        q     = (r1_bb >>> 2) - r1_ac;
        if (q < -big_e) begin
            n_cls = CLS_ZERO;
        end else if (r1_a_small) begin
            n_cls = r1_c_big ? CLS_ZERO : CLS_INF;
        end else if (q > big_e) begin
            n_cls = CLS_TWO;
        end else begin
            n_cls = CLS_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_q       <= (n_cls == CLS_TWO) ? q : '0;
            r2_sd.cls  <= n_cls;
            r2_sd.a    <= r1_a;
            r2_sd.b    <= r1_b;
            r2_sd.p1   <= r1_p1;
            r2_sd.p2   <= r1_p2;
            r2_sd.neg1 <= 1'b0;
            r2_sd.neg2 <= 1'b0;
        end
    end

    assign sq_v[0]    = r2_q;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar gi = 0; gi < SQ_ROOT_W; gi++) begin : g_sq
        sqi_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_v    (sq_v[gi]),
            .i_rem  (sq_rem[gi]),
            .i_root (sq_root[gi]),
            .o_v    (sq_v[gi+1]),
            .o_rem  (sq_rem[gi+1]),
            .o_root (sq_root[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_sd[0] <= r2_sd;
            for (int k = 1; k < SQ_ROOT_W; k++) begin
                r_sq_sd[k] <= r_sq_sd[k-1];
            end
        end
    end

    always_comb begin
        sq_out     = r_sq_sd[SQ_ROOT_W-1];
        mb         = -(36'(sq_out.b));
        s2         = $signed({3'b000, sq_root[SQ_ROOT_W], 1'b0});
        n1         = mb - s2;
        n2         = mb + s2;
        m1         = n1[35] ? -n1 : n1;
        m2         = n2[35] ? -n2 : n2;
        n3_sd      = sq_out;
        n3_sd.neg1 = n1[35];
        n3_sd.neg2 = n2[35];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dq1       <= {m1[NMAG_W-1:0], {FRAC_BITS{1'b0}}};
            r3_dq2       <= {m2[NMAG_W-1:0], {FRAC_BITS{1'b0}}};
            r3_dvs       <= {sq_out.a[WORD_W-2:0], 1'b0};
            r3_sd        <= n3_sd;
        end
    end

    assign dv_dq1[0]  = r3_dq1;
    assign dv_dq2[0]  = r3_dq2;
    assign dv_rem1[0] = '0;
    assign dv_rem2[0] = '0;
    assign dv_dvs1[0] = r3_dvs;
    assign dv_dvs2[0] = r3_dvs;

    for (genvar gi = 0; gi < DW; gi++) begin : g_dv
        sqi_div_cell #(.DW(DW)) u_cell1 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_dq  (dv_dq1[gi]),
            .i_rem (dv_rem1[gi]),
            .i_dvs (dv_dvs1[gi]),
            .o_dq  (dv_dq1[gi+1]),
            .o_rem (dv_rem1[gi+1]),
            .o_dvs (dv_dvs1[gi+1])
        );
        sqi_div_cell #(.DW(DW)) u_cell2 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_dq  (dv_dq2[gi]),
            .i_rem (dv_rem2[gi]),
            .i_dvs (dv_dvs2[gi]),
            .o_dq  (dv_dq2[gi+1]),
            .o_rem (dv_rem2[gi+1]),
            .o_dvs (dv_dvs2[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_sd[0] <= r3_sd;
            for (int k = 1; k < DW; k++) begin
                r_dv_sd[k] <= r_dv_sd[k-1];
            end
        end
    end

    // root range checks on sign and magnitude
    always_comb begin
        dv_out = r_dv_sd[DW-1];
        qt1    = dv_dq1[DW];
        qt2    = dv_dq2[DW];
        eps_q  = DW'(r_near_zero);
        ok1    = (!dv_out.neg1 || qt1 == '0) && (qt1 >= eps_q) &&
                 (dv_out.neg1 || qt1 <= ONE_Q);
        ok2    = (!dv_out.neg2 || qt2 == '0) && (qt2 >= eps_q) &&
                 (dv_out.neg2 || qt2 <= ONE_Q);
        gt1    = !dv_out.neg1 && (qt1 > ONE_Q);
        gt2    = !dv_out.neg2 && (qt2 > ONE_Q);
        lt1    = dv_out.neg1 && (qt1 != '0);
        lt2    = dv_out.neg2 && (qt2 != '0);
        n_kind = KIND_NONE;
        unique case (dv_out.cls)
            CLS_ZERO: n_kind = KIND_NONE;
            CLS_INF:  n_kind = KIND_INF;
            CLS_ONE:  n_kind = ok1 ? KIND_ONE : KIND_NONE;
            CLS_TWO: begin
                priority if (ok1 && ok2) begin
                    n_kind = KIND_TWO;
                end else if (ok1 || ok2) begin
                    n_kind = KIND_ONE;
                end else if ((gt1 && gt2) || (lt1 && lt2)) begin
                    n_kind = KIND_NONE;
                end else begin
                    n_kind = KIND_INF;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_kind <= n_kind;
            r5_uf   <= (n_kind == KIND_ONE) || (n_kind == KIND_TWO);
            r5_us   <= (n_kind == KIND_TWO);
            r5_tf   <= ok1 ? qt1[TW-1:0] : qt2[TW-1:0];
            r5_ts   <= qt2[TW-1:0];
            r5_p1   <= dv_out.p1;
            for (int k = 0; k < 3; k++) begin
                r5_d[k] <= $signed({dv_out.p2[k][WORD_W-1], dv_out.p2[k]}) -
                           $signed({dv_out.p1[k][WORD_W-1], dv_out.p1[k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_kind <= r5_kind;
            r6_uf   <= r5_uf;
            r6_us   <= r5_us;
            r6_p1   <= r5_p1;
            for (int k = 0; k < 3; k++) begin
                r6_pf[k] <= PW'($signed({1'b0, r5_tf})) * PW'(r5_d[k]);
                r6_ps[k] <= PW'($signed({1'b0, r5_ts})) * PW'(r5_d[k]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pts[k]   = r6_uf ? sat36(36'($signed(r6_pf[k][PW-1:FRAC_BITS])) +
                                       36'($signed(r6_p1[k]))) : '0;
            n_pts[k+3] = r6_us ? sat36(36'($signed(r6_ps[k][PW-1:FRAC_BITS])) +
                                       36'($signed(r6_p1[k]))) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_data <= n_pts;
            r7_user <= {(r6_kind != KIND_NONE), r6_kind};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r_vld[NST-1];
            end
        end else if (en && r_vld[NST-1]) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_axis_tready) begin
            r_out_d <= r_skid_v ? r_skid_d : r7_data;
            r_out_u <= r_skid_v ? r_skid_u : r7_user;
        end
        if (r_out_v && !i_m_axis_tready && en) begin
            r_skid_d <= r7_data;
            r_skid_u <= r7_user;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_d;
    assign o_m_axis_tuser  = r_out_u;

endmodule
`default_nettype wire

// ===== hw/rtl/sqi_checker.sv =====
`default_nettype none
module sqi_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [sqi_pkg::OUT_W-1:0]   o_m_axis_tdata,
    input logic [sqi_pkg::USER_W-1:0]  o_m_axis_tuser
);
    import sqi_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser[2] == (o_m_axis_tuser[1:0] != KIND_NONE))
        else $error("hit flag disagrees with kind");

    a_no_pts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == KIND_NONE ||
                            o_m_axis_tuser[1:0] == KIND_INF) |-> o_m_axis_tdata == '0)
        else $error("points present without a point hit");

    a_one_pt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1:0] == KIND_ONE |->
        o_m_axis_tdata[OUT_W-1:OUT_W/2] == '0)
        else $error("second point present on single hit");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind segment_quadratic_intersection_top sqi_checker u_sqi_checker (.*);
`default_nettype wire
